[rtl/core/pgpi_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pgpi_pkg
// Shared widths, codes and types for the proximity gated point insert block.
// ----------------------------------------------------------------------------
package pgpi_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int COORD_W     = 24;
    localparam int DIFF_W      = COORD_W + 1;
    localparam int SQ_W        = 2 * COORD_W + 1;
    localparam int DIST_W      = SQ_W + 2;
    localparam int ROW_W       = 3 * COORD_W;
    localparam int SEP_W       = 48;
    localparam int OUT_DATA_W  = ((IDX_W + 7) / 8) * 8;

    localparam logic [SEP_W-1:0] SEP_RESET = SEP_W'(262144);

    typedef enum logic [1:0] {
        PH_X,
        PH_Y,
        PH_Z
    } pgpi_axis_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE
    } pgpi_state_t;

    // one squared-difference step on its way through the distance unit
    typedef struct packed {
        logic             valid;
        logic             last;
        pgpi_axis_t       axis;
        logic [IDX_W-1:0] idx;
    } pgpi_step_t;

    // one finished entry distance
    typedef struct packed {
        logic             valid;
        logic             last;
        logic [IDX_W-1:0] idx;
    } pgpi_hit_t;

endpackage : pgpi_pkg
`default_nettype wire

[rtl/core/proximity_gated_point_insert.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// proximity_gated_point_insert
// Nearest stored point search with append when the query is far enough.
// ----------------------------------------------------------------------------
// Each request carries one 3-D point (24-bit signed coordinates, 8 fraction
// bits). The block scans all stored entries through one shared
// subtract/multiply/accumulate unit, one axis per cycle; on an empty table
// the scan is skipped. A new request is accepted only once the previous
// result has been moved into the output register. A reply held by m_tready
// low does not stop the next scan; the next result waits in ST_DECIDE until
// the output is free. If the table is empty or the nearest squared distance
// exceeds min_separation_sq, the point is appended and its new index returned
// with was_added set; a far point on a full table returns the nearest index
// with table_full set. Ties go to the lowest index. s_tready is low while a
// request is in progress. Write min_separation_sq only while no request is
// in progress.
// ----------------------------------------------------------------------------
module proximity_gated_point_insert
    import pgpi_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [SEP_W-1:0]      cfg_wdata,   // min_separation_sq
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [ROW_W-1:0]      s_tdata,     // pos_x, pos_y, pos_z
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,     // entry_index, zero pad
    output logic [1:0]                 m_tuser      // was_added, table_full
);

    pgpi_state_t           state_reg;
    pgpi_state_t           state_next;
    logic [SEP_W-1:0]      sep_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [COORD_W-1:0]    px_reg;
    logic [COORD_W-1:0]    py_reg;
    logic [COORD_W-1:0]    pz_reg;
    logic [IDX_W-1:0]      scan_idx_reg;
    pgpi_axis_t            axis_reg;
    pgpi_step_t            step_reg;
    logic [ROW_W-1:0]      rd_row_reg;
    logic [ROW_W-1:0]      mem [TABLE_DEPTH];
    logic [DIST_W-1:0]     best_reg;
    logic [IDX_W-1:0]      best_idx_reg;
    logic                  m_tvalid_reg;
    logic [IDX_W-1:0]      out_idx_reg;
    logic                  out_added_reg;
    logic                  out_full_reg;

    pgpi_hit_t             hit;
    logic [DIST_W-1:0]     dist_sq;
    logic [CNT_W-1:0]      count_dec;
    logic [IDX_W-1:0]      last_idx;
    logic                  scan_last;
    logic                  accept;
    logic                  issue;
    logic                  commit;
    logic                  out_free;
    logic                  far;
    logic                  has_room;
    logic                  do_add;
    logic                  do_full;
    logic [IDX_W-1:0]      res_idx;

    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign count_dec = count_reg - CNT_W'(1);
    assign last_idx  = count_dec[IDX_W-1:0];
    assign scan_last = (axis_reg == PH_Z) && (scan_idx_reg == last_idx);

    assign has_room  = count_reg < CNT_W'(TABLE_DEPTH);
    assign far       = (count_reg == '0) || (best_reg > DIST_W'(sep_reg));
    assign do_add    = far && has_room;
    assign do_full   = far && !has_room;
    assign res_idx   = do_add ? count_reg[IDX_W-1:0] : best_idx_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = (count_reg == '0) ? ST_DECIDE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (hit.valid && hit.last)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        s_tready = 1'b0;
        issue    = 1'b0;
        commit   = 1'b0;
        unique case (state_reg)
            ST_IDLE:   s_tready = 1'b1;
            ST_SCAN:   issue    = 1'b1;
            ST_DRAIN:  ;
            ST_DECIDE: commit   = out_free;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            sep_reg      <= SEP_RESET;
            count_reg    <= '0;
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg.valid <= issue;
            step_reg.last  <= scan_last;
            step_reg.axis  <= axis_reg;
            step_reg.idx   <= scan_idx_reg;
            if (cfg_we)
            begin
                sep_reg <= cfg_wdata;
            end
            if (commit && do_add)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (commit)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // query point, scan position, best candidate, result
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg       <= s_tdata[COORD_W-1:0];
            py_reg       <= s_tdata[2*COORD_W-1:COORD_W];
            pz_reg       <= s_tdata[3*COORD_W-1:2*COORD_W];
            scan_idx_reg <= '0;
            axis_reg     <= PH_X;
        end
        else if (issue)
        begin
            unique case (axis_reg)
                PH_X: axis_reg <= PH_Y;
                PH_Y: axis_reg <= PH_Z;
                PH_Z:
                begin
                    axis_reg     <= PH_X;
                    scan_idx_reg <= scan_idx_reg + IDX_W'(1);
                end
                default: axis_reg <= PH_X;
            endcase
        end

        if (hit.valid && ((hit.idx == '0) || (dist_sq < best_reg)))
        begin
            best_reg     <= dist_sq;
            best_idx_reg <= hit.idx;
        end

        if (commit)
        begin
            out_idx_reg   <= res_idx;
            out_added_reg <= do_add;
            out_full_reg  <= do_full;
        end
    end

    // point table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (commit && do_add)
        begin
            mem[count_reg[IDX_W-1:0]] <= {pz_reg, py_reg, px_reg};
        end
        rd_row_reg <= mem[scan_idx_reg];
    end

    pgpi_dist_unit u_dist (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step_reg),
        .row     (rd_row_reg),
        .qx      (px_reg),
        .qy      (py_reg),
        .qz      (pz_reg),
        .hit     (hit),
        .dist_sq (dist_sq)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_DATA_W'(out_idx_reg);
    assign m_tuser  = {out_full_reg, out_added_reg};

endmodule : proximity_gated_point_insert
`default_nettype wire

[rtl/core/pgpi_dist_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pgpi_dist_unit
// Shared squared-distance unit: one subtractor, one multiplier and one
// accumulator, fed one axis per cycle and returning one distance per entry.
// ----------------------------------------------------------------------------
module pgpi_dist_unit
    import pgpi_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire pgpi_step_t          step,
    input  wire logic [ROW_W-1:0]    row,
    input  wire logic [COORD_W-1:0]  qx,
    input  wire logic [COORD_W-1:0]  qy,
    input  wire logic [COORD_W-1:0]  qz,
    output pgpi_hit_t                hit,
    output logic [DIST_W-1:0]        dist_sq
);

    logic [COORD_W-1:0]        s_coord;
    logic [COORD_W-1:0]        q_coord;
    logic signed [DIFF_W-1:0]  diff_next;
    logic signed [DIFF_W-1:0]  diff_reg;
    logic signed [2*DIFF_W-1:0] prod_full;
    logic [SQ_W-1:0]           prod_reg;
    logic [DIST_W-1:0]         acc_reg;
    logic [DIST_W-1:0]         dist_reg;
    pgpi_step_t                tag_c_reg;
    pgpi_step_t                tag_d_reg;
    pgpi_hit_t                 hit_reg;

    always_comb
    begin
        unique case (step.axis)
            PH_X:
            begin
                s_coord = row[COORD_W-1:0];
                q_coord = qx;
            end
            PH_Y:
            begin
                s_coord = row[2*COORD_W-1:COORD_W];
                q_coord = qy;
            end
            PH_Z:
            begin
                s_coord = row[3*COORD_W-1:2*COORD_W];
                q_coord = qz;
            end
            default:
            begin
                s_coord = row[COORD_W-1:0];
                q_coord = qx;
            end
        endcase
        diff_next = $signed({s_coord[COORD_W-1], s_coord})
                  - $signed({q_coord[COORD_W-1], q_coord});
    end

    assign prod_full = diff_reg * diff_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_c_reg <= '0;
            tag_d_reg <= '0;
            hit_reg   <= '0;
        end
        else
        begin
            tag_c_reg     <= step;
            tag_d_reg     <= tag_c_reg;
            hit_reg.valid <= tag_d_reg.valid && (tag_d_reg.axis == PH_Z);
            hit_reg.last  <= tag_d_reg.last;
            hit_reg.idx   <= tag_d_reg.idx;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg <= diff_next;
        prod_reg <= prod_full[SQ_W-1:0];

        if (tag_d_reg.valid)
        begin
            unique case (tag_d_reg.axis)
                PH_X:    acc_reg  <= DIST_W'(prod_reg);
                PH_Y:    acc_reg  <= acc_reg + DIST_W'(prod_reg);
                PH_Z:    dist_reg <= acc_reg + DIST_W'(prod_reg);
                default: acc_reg  <= DIST_W'(prod_reg);
            endcase
        end
    end

    assign hit     = hit_reg;
    assign dist_sq = dist_reg;

endmodule : pgpi_dist_unit
`default_nettype wire

[test/proximity_gated_point_insert_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// proximity_gated_point_insert_tb
// Self-checking bench for the nearest-point search with gated append.
// ----------------------------------------------------------------------------
// A queue of requests (points and threshold writes) feeds a stream driver. A
// monitor keeps its own copy of the point table, count and threshold, predicts
// the reply of every accepted point and checks the replies in order. Directed
// points cover the empty table, first-index ties, the threshold boundary and
// the coordinate extremes. Random phases run under several thresholds, from
// zero to all ones. The table is then filled to capacity so that far points
// draw full-table replies.
// ----------------------------------------------------------------------------
module proximity_gated_point_insert_tb;
    import pgpi_pkg::*;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef enum logic {
        REQ_POINT,
        REQ_THRESHOLD
    } req_kind_t;

    typedef struct packed {
        req_kind_t        kind;
        logic [ROW_W-1:0] payload;
    } request_t;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic             added;
        logic             full;
    } reply_t;

    localparam coord_t           C_MAX         = coord_t'({1'b0, {(COORD_W-1){1'b1}}});
    localparam coord_t           C_MIN         = coord_t'({1'b1, {(COORD_W-1){1'b0}}});
    localparam logic [SEP_W-1:0] SEP_MAX       = '1;
    localparam int               IDLE_PCT      = 27;
    localparam int               SETTLE_CYCLES = 4;
    localparam int               TAIL_CYCLES   = 50;

    logic                  clk       = 1'b0;
    logic                  rst_n;
    logic                  cfg_we    = 1'b0;
    logic [SEP_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [ROW_W-1:0]      s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [1:0]            m_tuser;

    coord_t           tbl_x [TABLE_DEPTH];
    coord_t           tbl_y [TABLE_DEPTH];
    coord_t           tbl_z [TABLE_DEPTH];
    int               stored_cnt = 0;
    logic [SEP_W-1:0] sep_thr    = SEP_RESET;

    request_t         request_queue[$];
    reply_t           predicted_replies[$];
    logic [ROW_W-1:0] drawn_points[$];

    logic point_taken  = 1'b0;
    int   points_taken = 0;
    int   full_replies = 0;
    int   thr_writes   = 0;
    int   error_count  = 0;
    int   quiet        = 0;
    wire  steady       = points_taken >= 250 && points_taken < 340;

    proximity_gated_point_insert dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 clk = ~clk;

    function automatic logic [63:0] axis_sq(coord_t a, coord_t b);
        longint d;
        d = longint'(a) - longint'(b);
        return d * d;
    endfunction

    // Sums stay below 2**50, so no saturation is needed at this width.
    task automatic place_point(input logic [ROW_W-1:0] pt, output reply_t r);
        coord_t      px;
        coord_t      py;
        coord_t      pz;
        logic [63:0] dist_sq;
        logic [63:0] best;
        int          near_idx;
        int          i;
        logic        far;
        px       = pt[COORD_W-1:0];
        py       = pt[2*COORD_W-1:COORD_W];
        pz       = pt[3*COORD_W-1:2*COORD_W];
        best     = '0;
        near_idx = 0;
        far      = 1'b1;
        r        = '0;
        for (i = 0; i < stored_cnt; i++)
        begin
            dist_sq = axis_sq(tbl_x[i], px) + axis_sq(tbl_y[i], py) + axis_sq(tbl_z[i], pz);
            if (i == 0 || dist_sq < best)
            begin
                best     = dist_sq;
                near_idx = i;
            end
        end
        if (stored_cnt > 0)
            far = best > 64'(sep_thr);
        if (far && stored_cnt < TABLE_DEPTH)
        begin
            tbl_x[stored_cnt] = px;
            tbl_y[stored_cnt] = py;
            tbl_z[stored_cnt] = pz;
            r.index = IDX_W'(stored_cnt);
            r.added = 1'b1;
            stored_cnt++;
        end
        else
        begin
            r.index = IDX_W'(near_idx);
            r.full  = far;
        end
    endtask

    task automatic push_point(coord_t x, coord_t y, coord_t z);
        request_t r;
        r.kind    = REQ_POINT;
        r.payload = {z, y, x};
        request_queue.insert(request_queue.size(), r);
        drawn_points.insert(drawn_points.size(), r.payload);
    endtask

    task automatic push_threshold(logic [SEP_W-1:0] v);
        request_t r;
        r.kind    = REQ_THRESHOLD;
        r.payload = ROW_W'(v);
        request_queue.insert(request_queue.size(), r);
    endtask

    function automatic coord_t jitter(coord_t c, int spread);
        int v;
        v = int'(c) + int'($urandom_range(2 * spread)) - spread;
        if (v > int'(C_MAX))
            v = int'(C_MAX);
        if (v < int'(C_MIN))
            v = int'(C_MIN);
        return coord_t'(v);
    endfunction

    task automatic random_phase(int count, int spread, int far_pct);
        int               n;
        int               pick;
        int               s;
        logic [ROW_W-1:0] src;
        for (n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < far_pct)
                push_point(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
            else
            begin
                src = drawn_points[$urandom_range(drawn_points.size() - 1)];
                s   = (pick < far_pct + 20) ? 0 : spread;
                push_point(jitter(src[COORD_W-1:0], s),
                           jitter(src[2*COORD_W-1:COORD_W], s),
                           jitter(src[3*COORD_W-1:2*COORD_W], s));
            end
        end
    endtask

    task automatic drain();
        while (request_queue.size() != 0 || predicted_replies.size() != 0 || s_tvalid)
            @(posedge clk);
    endtask

    always @(negedge clk)
    begin : drive
        logic             nxt_valid;
        logic [ROW_W-1:0] nxt_data;
        logic             nxt_we;
        logic [SEP_W-1:0] nxt_wdata;
        request_t         head;
        nxt_valid = s_tvalid && !point_taken;
        nxt_data  = s_tdata;
        nxt_we    = 1'b0;
        nxt_wdata = cfg_wdata;
        quiet     = (predicted_replies.size() == 0 && !s_tvalid) ? quiet + 1 : 0;
        if (rst_n && !nxt_valid && request_queue.size() > 0)
        begin
            if (request_queue[0].kind == REQ_THRESHOLD)
            begin
                if (quiet > SETTLE_CYCLES)
                begin
                    head      = request_queue.pop_front();
                    nxt_we    = 1'b1;
                    nxt_wdata = head.payload[SEP_W-1:0];
                    quiet     = 0;
                end
            end
            else if (steady || $urandom_range(99) >= IDLE_PCT)
            begin
                head      = request_queue.pop_front();
                nxt_valid = 1'b1;
                nxt_data  = head.payload;
            end
        end
        s_tvalid  <= nxt_valid;
        s_tdata   <= nxt_data;
        cfg_we    <= nxt_we;
        cfg_wdata <= nxt_wdata;
        m_tready  <= steady || $urandom_range(99) >= IDLE_PCT;
    end

    always @(posedge clk)
    begin : watch
        reply_t due;
        reply_t fresh;
        point_taken <= s_tvalid && s_tready;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                sep_thr = cfg_wdata;
                thr_writes++;
            end
            if (m_tvalid && m_tready)
            begin
                full_replies += m_tuser[1];
                if (predicted_replies.size() == 0)
                begin
                    $display("%0t: reply with none expected: tdata %h tuser %b",
                             $time, m_tdata, m_tuser);
                    error_count++;
                end
                else
                begin
                    due = predicted_replies.pop_front();
                    if (m_tdata !== OUT_DATA_W'(due.index))
                    begin
                        $display("%0t: entry_index expected %0d got %0d (tdata %h)",
                                 $time, due.index, m_tdata[IDX_W-1:0], m_tdata);
                        error_count++;
                    end
                    if (m_tuser[0] !== due.added)
                    begin
                        $display("%0t: was_added expected %b got %b",
                                 $time, due.added, m_tuser[0]);
                        error_count++;
                    end
                    if (m_tuser[1] !== due.full)
                    begin
                        $display("%0t: table_full expected %b got %b",
                                 $time, due.full, m_tuser[1]);
                        error_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                place_point(s_tdata, fresh);
                predicted_replies.insert(predicted_replies.size(), fresh);
                points_taken++;
            end
        end
    end

    initial
    begin : stimulus
        int n;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        push_point(0, 0, 0);
        push_point(0, 0, 0);
        push_point(514, 0, 0);
        push_point(257, 0, 0);
        push_point(0, 512, 0);
        push_point(0, -513, 0);
        push_point(C_MAX, C_MAX, C_MAX);
        push_point(C_MIN, C_MIN, C_MIN);
        push_point(C_MIN, C_MAX, C_MIN);
        push_point(C_MAX, C_MIN, C_MAX);
        push_threshold(SEP_MAX);
        push_point(-1, -1, -1);
        push_point(0, C_MAX, 0);
        push_point(C_MAX, C_MAX, C_MIN);
        push_threshold('0);
        push_point(257, 0, 0);
        push_point(514, 0, 0);
        push_point(C_MIN, C_MIN, C_MIN);
        push_threshold(SEP_RESET);

        random_phase(100, 200, 10);
        push_threshold('0);
        random_phase(100, 0, 8);
        push_threshold(SEP_MAX);
        random_phase(100, 1 << 22, 15);
        push_threshold({16'h0, $urandom});
        random_phase(100, 1 << 12, 12);
        push_threshold(SEP_W'(1));
        random_phase(80, 1, 5);
        push_threshold({16'($urandom), $urandom});
        random_phase(100, 1 << 20, 10);

        // fill every free entry with distinct far points
        push_threshold('0);
        drain();
        while (stored_cnt < TABLE_DEPTH)
        begin
            for (n = stored_cnt; n < TABLE_DEPTH; n++)
                push_point(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
            drain();
        end

        push_point(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
        push_point(C_MAX, C_MIN, 0);
        push_point(tbl_x[TABLE_DEPTH-1], tbl_y[TABLE_DEPTH-1], tbl_z[TABLE_DEPTH-1]);
        push_point(tbl_x[0], tbl_y[0], tbl_z[0]);
        push_threshold(SEP_MAX);
        push_point(C_MAX, C_MAX, C_MAX);
        push_point(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
        push_threshold(SEP_RESET);
        push_point(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
        push_point(jitter(tbl_x[5], 100), jitter(tbl_y[5], 100), jitter(tbl_z[5], 100));

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Checked %0d points across %0d threshold writes.", points_taken, thr_writes);
        $display("Table reached %0d entries; %0d replies flagged the table full.",
                 stored_cnt, full_replies);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin : watchdog
        #200_000_000;
        $display("Timed out with %0d points checked.", points_taken);
        $display("== FAIL ==");
        $finish;
    end

endmodule
